FILE: hdl/bcomp_pkg.sv
// Shared constants, types and helpers of the barometer compensation block.
// No dependencies; every other file imports this package.
package bcomp_pkg;

   localparam int DIV_W      = 32;
   localparam int DIV_STAGES = DIV_W;
   localparam int CSR_IDX_W  = 3;

   localparam int PIPE_PRE  = 4;
   localparam int PIPE_MID  = 9;
   localparam int PIPE_TAIL = 3;

   localparam logic [CSR_IDX_W-1:0] REG_AC1_AC2 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_AC3_AC4 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_AC5_AC6 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_B1_B2   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MC_MD   = 3'd4;

   localparam logic [31:0] T_ROUND   = 32'd8;
   localparam logic [31:0] B5_OFFSET = 32'd4000;
   localparam logic [31:0] X3_BIAS   = 32'd32768;
   localparam logic [31:0] B7_SCALE  = 32'd50000;
   localparam logic [31:0] P_SQ_K    = 32'd3038;
   localparam logic [31:0] P_LIN_K   = 32'hFFFFE343;
   localparam logic [31:0] P_OFFSET  = 32'd3791;
   localparam logic [17:0] P_MAX     = 18'h3FFFF;

   typedef struct packed {
      logic [31:0] x1;
      logic [15:0] up;
      logic        neg;
      logic        tz;
   } side1_type;

   typedef struct packed {
      logic [15:0] t;
      logic        tz;
      logic        pz;
      logic        shift;
   } side2_type;

   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

endpackage

FILE: hdl/bcomp_div.sv
// Pipelined unsigned 32/32 restoring divider, one quotient bit per stage.
// Depends on bcomp_pkg for the width and stage count.
module bcomp_div import bcomp_pkg::*; (
   input  logic             clock,
   input  logic             en,
   input  logic [DIV_W-1:0] num,
   input  logic [DIV_W-1:0] den,
   output logic [DIV_W-1:0] quo
);

   logic [DIV_W-1:0] rem_ff [DIV_STAGES];
   logic [DIV_W-1:0] nq_ff  [DIV_STAGES];
   logic [DIV_W-1:0] dd_ff  [DIV_STAGES];
   logic [DIV_W-1:0] rem_in [DIV_STAGES];
   logic [DIV_W-1:0] nq_in  [DIV_STAGES];
   logic [DIV_W-1:0] dd_in  [DIV_STAGES];

   always_comb begin
      logic [DIV_W-1:0] r;
      logic [DIV_W-1:0] n;
      logic [DIV_W-1:0] d;
      logic [DIV_W:0]   sh;
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (k == 0) begin
            r = '0;
            n = num;
            d = den;
         end else begin
            r = rem_ff[k-1];
            n = nq_ff[k-1];
            d = dd_ff[k-1];
         end
         sh = {r, n[DIV_W-1]};
         dd_in[k] = d;
         if (sh >= {1'b0, d}) begin
            rem_in[k] = DIV_W'(sh - {1'b0, d});
            nq_in[k]  = {n[DIV_W-2:0], 1'b1};
         end else begin
            rem_in[k] = sh[DIV_W-1:0];
            nq_in[k]  = {n[DIV_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            rem_ff[k] <= rem_in[k];
            nq_ff[k]  <= nq_in[k];
            dd_ff[k]  <= dd_in[k];
         end
      end
   end

   assign quo = nq_ff[DIV_STAGES-1];

endmodule

FILE: hdl/barometer_compensation.sv
// Barometer compensation: raw temperature and pressure words in, compensated
// temperature (0.1 C) and pressure (Pa) out, one item per cycle sustained.
// Two 32-stage dividers (temperature, then pressure) lie in series with the
// multiply stages. The whole pipeline advances together and holds while a
// result waits on rsp_tready.
// Depends on bcomp_pkg and bcomp_div.
module barometer_compensation import bcomp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [31:0]          req_tdata,   // raw_temperature[15:0], raw_pressure[31:16]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [39:0]          rsp_tdata,   // temperature_tenths[15:0], pressure_pa[33:16]
   output logic                 rsp_tuser,   // division_fault
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   logic [31:0] coef01_ff, coef23_ff, coef45_ff, coefb_ff, coefm_ff;
   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef01_ff <= '0;
         coef23_ff <= '0;
         coef45_ff <= '0;
         coefb_ff  <= '0;
         coefm_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_AC1_AC2: coef01_ff <= csr_data;
            REG_AC3_AC4: coef23_ff <= csr_data;
            REG_AC5_AC6: coef45_ff <= csr_data;
            REG_B1_B2:   coefb_ff  <= csr_data;
            REG_MC_MD:   coefm_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign ac1 = sx16(coef01_ff[31:16]);
   assign ac2 = sx16(coef01_ff[15:0]);
   assign ac3 = sx16(coef23_ff[31:16]);
   assign ac4 = {16'd0, coef23_ff[15:0]};
   assign ac5 = {16'd0, coef45_ff[31:16]};
   assign ac6 = {16'd0, coef45_ff[15:0]};
   assign b1  = sx16(coefb_ff[31:16]);
   assign b2  = sx16(coefb_ff[15:0]);
   assign mc  = sx16(coefm_ff[31:16]);
   assign md  = sx16(coefm_ff[15:0]);

   logic en;
   logic rsp_tvalid_ff;
   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = rsp_tvalid_ff;

   // valid bits: pre-divider stages, divider 1, middle stages, divider 2, tail
   logic [PIPE_PRE-1:0]   vpre_ff;
   logic [DIV_STAGES-1:0] vd1_ff;
   logic [PIPE_MID-1:0]   vmid_ff;
   logic [DIV_STAGES-1:0] vd2_ff;
   logic [PIPE_TAIL-1:0]  vtail_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vpre_ff       <= '0;
         vd1_ff        <= '0;
         vmid_ff       <= '0;
         vd2_ff        <= '0;
         vtail_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         vpre_ff       <= {vpre_ff[PIPE_PRE-2:0], req_tvalid};
         vd1_ff        <= {vd1_ff[DIV_STAGES-2:0], vpre_ff[PIPE_PRE-1]};
         vmid_ff       <= {vmid_ff[PIPE_MID-2:0], vd1_ff[DIV_STAGES-1]};
         vd2_ff        <= {vd2_ff[DIV_STAGES-2:0], vmid_ff[PIPE_MID-1]};
         vtail_ff      <= {vtail_ff[PIPE_TAIL-2:0], vd2_ff[DIV_STAGES-1]};
         rsp_tvalid_ff <= vtail_ff[PIPE_TAIL-1];
      end
   end

   // ---- temperature front end ----
   logic [15:0] a_ut_ff, a_up_ff;
   logic [31:0] b_m_ff, b_m_in;
   logic [15:0] b_up_ff;
   logic [31:0] c_x1_ff, c_x1_in, c_den_ff, c_den_in;
   logic [15:0] c_up_ff;
   logic [31:0] d_anum_ff, d_anum_in, d_aden_ff, d_aden_in;
   side1_type   d_side_ff, d_side_in;
   logic [31:0] mcs;

   assign b_m_in   = ({16'd0, a_ut_ff} - ac6) * ac5;
   assign c_x1_in  = 32'($signed(b_m_ff) >>> 15);
   assign c_den_in = c_x1_in + md;
   assign mcs       = mc << 11;
   assign d_anum_in = mcs[31] ? 32'(-mcs) : mcs;
   assign d_aden_in = c_den_ff[31] ? 32'(-c_den_ff) : c_den_ff;
   assign d_side_in = '{x1: c_x1_ff, up: c_up_ff, neg: mcs[31] ^ c_den_ff[31],
                        tz: (c_den_ff == '0)};

   always_ff @(posedge clock) begin
      if (en) begin
         a_ut_ff   <= req_tdata[15:0];
         a_up_ff   <= req_tdata[31:16];
         b_m_ff    <= b_m_in;
         b_up_ff   <= a_up_ff;
         c_x1_ff   <= c_x1_in;
         c_den_ff  <= c_den_in;
         c_up_ff   <= b_up_ff;
         d_anum_ff <= d_anum_in;
         d_aden_ff <= d_aden_in;
         d_side_ff <= d_side_in;
      end
   end

   logic [31:0] q1;
   side1_type   s1_ff [DIV_STAGES];

   bcomp_div u_div_t (
      .clock (clock),
      .en    (en),
      .num   (d_anum_ff),
      .den   (d_aden_ff),
      .quo   (q1)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff[0] <= d_side_ff;
         for (int k = 1; k < DIV_STAGES; k++) s1_ff[k] <= s1_ff[k-1];
      end
   end

   // ---- middle: b5 through b4 and b7 ----
   side1_type   s1o;
   logic [31:0] e_b5_ff, e_b5_in;
   logic [15:0] e_up_ff, f_up_ff, g_up_ff, h_up_ff, i_up_ff, j_up_ff;
   logic        e_tz_ff;
   logic [31:0] tsum;
   logic [15:0] f_t_ff, f_t_in;
   logic [31:0] f_b6_ff, f_b6_in;
   logic [31:0] g_sqm_ff, g_sqm_in, g_a2_ff, g_a2_in, g_a3_ff, g_a3_in;
   logic [31:0] h_sq_ff, h_sq_in, h_x2a_ff, h_x2a_in, h_x1c_ff, h_x1c_in;
   logic [31:0] i_b2sq_ff, i_b2sq_in, i_b1sq_ff, i_b1sq_in, i_x2a_ff, i_x1c_ff;
   logic [31:0] jx1, jx2;
   logic [31:0] j_b3_ff, j_b3_in, j_x3p_ff, j_x3p_in;
   logic [31:0] k_b4m_ff, k_b4m_in, k_upb3_ff, k_upb3_in;
   logic [31:0] l_b4_ff, l_b4_in, l_b7_ff, l_b7_in;
   logic [31:0] m_num_ff, m_num_in, m_den_ff;
   side2_type   st_f_ff, st_g_ff, st_h_ff, st_i_ff, st_j_ff, st_k_ff, st_l_ff;
   side2_type   m_side_ff, m_side_in;

   assign s1o     = s1_ff[DIV_STAGES-1];
   assign e_b5_in = s1o.x1 + (s1o.neg ? 32'(-q1) : q1);
   assign tsum    = 32'($signed(e_b5_ff + T_ROUND) >>> 4);
   assign f_t_in  = ($signed(tsum) > 32'sd32767) ? 16'h7FFF :
                    ($signed(tsum) < -32'sd32768) ? 16'h8000 : tsum[15:0];
   assign f_b6_in = e_b5_ff - B5_OFFSET;
   assign g_sqm_in = f_b6_ff * f_b6_ff;
   assign g_a2_in  = ac2 * f_b6_ff;
   assign g_a3_in  = ac3 * f_b6_ff;
   assign h_sq_in  = 32'($signed(g_sqm_ff) >>> 12);
   assign h_x2a_in = 32'($signed(g_a2_ff) >>> 11);
   assign h_x1c_in = 32'($signed(g_a3_ff) >>> 13);
   assign i_b2sq_in = b2 * h_sq_ff;
   assign i_b1sq_in = b1 * h_sq_ff;
   assign jx1      = 32'($signed(i_b2sq_ff) >>> 11);
   assign jx2      = 32'($signed(i_b1sq_ff) >>> 16);
   assign j_b3_in  = 32'($signed((ac1 << 2) + jx1 + i_x2a_ff + 32'd2) >>> 2);
   assign j_x3p_in = 32'($signed(i_x1c_ff + jx2 + 32'd2) >>> 2) + X3_BIAS;
   assign k_b4m_in  = ac4 * j_x3p_ff;
   assign k_upb3_in = {16'd0, j_up_ff} - j_b3_ff;
   assign l_b4_in   = k_b4m_ff >> 15;
   assign l_b7_in   = k_upb3_ff * B7_SCALE;
   assign m_num_in  = l_b7_ff[31] ? l_b7_ff : (l_b7_ff << 1);
   assign m_side_in = '{t: st_l_ff.t, tz: st_l_ff.tz, pz: (l_b4_ff == '0),
                        shift: l_b7_ff[31]};

   always_ff @(posedge clock) begin
      if (en) begin
         e_b5_ff   <= e_b5_in;
         e_up_ff   <= s1o.up;
         e_tz_ff   <= s1o.tz;
         f_t_ff    <= f_t_in;
         f_b6_ff   <= f_b6_in;
         f_up_ff   <= e_up_ff;
         st_f_ff   <= '{t: f_t_in, tz: e_tz_ff, pz: 1'b0, shift: 1'b0};
         g_sqm_ff  <= g_sqm_in;
         g_a2_ff   <= g_a2_in;
         g_a3_ff   <= g_a3_in;
         g_up_ff   <= f_up_ff;
         st_g_ff   <= st_f_ff;
         h_sq_ff   <= h_sq_in;
         h_x2a_ff  <= h_x2a_in;
         h_x1c_ff  <= h_x1c_in;
         h_up_ff   <= g_up_ff;
         st_h_ff   <= st_g_ff;
         i_b2sq_ff <= i_b2sq_in;
         i_b1sq_ff <= i_b1sq_in;
         i_x2a_ff  <= h_x2a_ff;
         i_x1c_ff  <= h_x1c_ff;
         i_up_ff   <= h_up_ff;
         st_i_ff   <= st_h_ff;
         j_b3_ff   <= j_b3_in;
         j_x3p_ff  <= j_x3p_in;
         j_up_ff   <= i_up_ff;
         st_j_ff   <= st_i_ff;
         k_b4m_ff  <= k_b4m_in;
         k_upb3_ff <= k_upb3_in;
         st_k_ff   <= st_j_ff;
         l_b4_ff   <= l_b4_in;
         l_b7_ff   <= l_b7_in;
         st_l_ff   <= st_k_ff;
         m_num_ff  <= m_num_in;
         m_den_ff  <= l_b4_ff;
         m_side_ff <= m_side_in;
      end
   end

   // ---- pressure division and tail ----
   logic [31:0] q2;
   side2_type   s2_ff [DIV_STAGES];

   bcomp_div u_div_p (
      .clock (clock),
      .en    (en),
      .num   (m_num_ff),
      .den   (m_den_ff),
      .quo   (q2)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ff[0] <= m_side_ff;
         for (int k = 1; k < DIV_STAGES; k++) s2_ff[k] <= s2_ff[k-1];
      end
   end

   side2_type   s2o, n_side_ff, o_side_ff, p_side_ff;
   logic [31:0] n_p_ff, n_p_in, n_x1_ff, n_x1_in;
   logic [31:0] o_p_ff, o_x1sq_ff, o_x1sq_in, o_x2m_ff, o_x2m_in;
   logic [31:0] p_p_ff, p_m3_ff, p_m3_in, p_x2m_ff;
   logic [31:0] qx1, qx2, pf;
   logic [15:0] rsp_t_ff, rsp_t_in;
   logic [17:0] rsp_p_ff, rsp_p_in;
   logic        rsp_f_ff, rsp_f_in;

   assign s2o       = s2_ff[DIV_STAGES-1];
   assign n_p_in    = s2o.shift ? (q2 << 1) : q2;
   assign n_x1_in   = 32'($signed(n_p_in) >>> 8);
   assign o_x1sq_in = n_x1_ff * n_x1_ff;
   assign o_x2m_in  = n_p_ff * P_LIN_K;
   assign p_m3_in   = o_x1sq_ff * P_SQ_K;
   assign qx1       = 32'($signed(p_m3_ff) >>> 16);
   assign qx2       = 32'($signed(p_x2m_ff) >>> 16);
   assign pf        = p_p_ff + 32'($signed(qx1 + qx2 + P_OFFSET) >>> 4);

   always_comb begin
      rsp_t_in = p_side_ff.t;
      rsp_f_in = p_side_ff.tz || p_side_ff.pz;
      if ($signed(pf) < 32'sd0) rsp_p_in = '0;
      else if ($signed(pf) > $signed({14'd0, P_MAX})) rsp_p_in = P_MAX;
      else rsp_p_in = pf[17:0];
      if (p_side_ff.tz) begin
         rsp_t_in = '0;
      end
      if (rsp_f_in) begin
         rsp_p_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_p_ff    <= n_p_in;
         n_x1_ff   <= n_x1_in;
         n_side_ff <= s2o;
         o_p_ff    <= n_p_ff;
         o_x1sq_ff <= o_x1sq_in;
         o_x2m_ff  <= o_x2m_in;
         o_side_ff <= n_side_ff;
         p_p_ff    <= o_p_ff;
         p_m3_ff   <= p_m3_in;
         p_x2m_ff  <= o_x2m_ff;
         p_side_ff <= o_side_ff;
         rsp_t_ff  <= rsp_t_in;
         rsp_p_ff  <= rsp_p_in;
         rsp_f_ff  <= rsp_f_in;
      end
   end

   assign rsp_tdata = {6'd0, rsp_p_ff, rsp_t_ff};
   assign rsp_tuser = rsp_f_ff;

   a_fault_zero_p: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[33:16] == 18'd0)
      else $error("fault item carries nonzero pressure");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid && vtail_ff == '0)
      else $error("pipeline not empty after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(en) && !$past(reset) |-> $stable(vd1_ff) && $stable(vd2_ff))
      else $error("divider valid bits moved during stall");

endmodule
